@@ hdl/rdf_pkg.sv @@
// rdf_pkg: widths, character codes and the digit-to-ascii mapping for the
// radix digit formatter; no dependencies
package rdf_pkg;

   // field widths
   localparam int VALUE_W     = 32;
   localparam int BIT_W       = 5;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int COUNT_W     = 6;

   // configuration and sizing
   localparam int DIGIT_SLOTS_DEFAULT = 32;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   // results per run, newline included
   localparam int MAX_RESULTS = 40;
   localparam logic [COUNT_W-1:0] CHAR_CAP = COUNT_W'(MAX_RESULTS - 1);

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LETTER  = 7'h41;
   localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

   // digit 0..35 to '0'..'9', 'A'..'Z'
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] ch;
      if (d < DECIMAL_DIGITS) begin
         ch = CHAR_ZERO + {1'b0, d};
      end else begin
         ch = CHAR_LETTER + {1'b0, d - DECIMAL_DIGITS};
      end
      return ch;
   endfunction

endpackage

@@ hdl/rdf_req_if.sv @@
// rdf_req_if: request channel carrying the value to print
// depends on rdf_pkg
interface rdf_req_if;
   logic                          valid;
   logic                          ready;
   logic [rdf_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/rdf_rsp_if.sv @@
// rdf_rsp_if: response channel carrying one character per transfer
// depends on rdf_pkg
interface rdf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rdf_pkg::CHAR_W-1:0]    character;
   logic                          last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

@@ hdl/rdf_csr_if.sv @@
// rdf_csr_if: write channel for the radix register
// depends on rdf_pkg
interface rdf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rdf_pkg::RADIX_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/radix_digit_formatter.sv @@
// radix_digit_formatter: a bit-serial divider (one quotient bit per cycle)
// fills every digit slot, then each slot is read through the registered
// digit-memory read (ST_RD, ST_LOOK) and its characters are sent, each held
// while the response stalls. One request at a time. Synchronous reset:
// idle, radix = 10.
module radix_digit_formatter #(
   parameter int DIGIT_SLOTS = rdf_pkg::DIGIT_SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   rdf_req_if.sink       req,
   rdf_rsp_if.source     rsp,
   rdf_csr_if.sink       csr
);

   localparam int SLOT_W = $clog2(DIGIT_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(DIGIT_SLOTS - 1);
   localparam logic [rdf_pkg::BIT_W-1:0] BIT_LAST = rdf_pkg::BIT_W'(rdf_pkg::VALUE_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_RD, ST_LOOK, ST_SEND, ST_TAIL
   } state_type;

   state_type                      state_ff;
   logic [rdf_pkg::RADIX_W-1:0]    radix_ff;
   logic [rdf_pkg::RADIX_W-1:0]    base_ff;
   logic [rdf_pkg::RADIX_W-1:0]    base_in;
   logic [rdf_pkg::VALUE_W-1:0]    quot_ff;
   logic [rdf_pkg::RADIX_W-1:0]    rem_ff;
   logic [rdf_pkg::BIT_W-1:0]      bit_ff;
   logic [SLOT_W-1:0]              slot_ff;
   logic [rdf_pkg::COUNT_W-1:0]    cnt_ff;
   logic                           started_ff;
   logic                           pend_ff;
   logic                           last_ff;
   logic [rdf_pkg::CHAR_W-1:0]     char_ff;
   logic [rdf_pkg::RADIX_W-1:0]    rd_ff;
   logic [rdf_pkg::RADIX_W-1:0]    digit_mem [DIGIT_SLOTS];

   logic [rdf_pkg::RADIX_W:0]      rem_shift;
   logic                           rem_ge;
   logic [rdf_pkg::RADIX_W:0]      rem_diff;
   logic [rdf_pkg::RADIX_W-1:0]    rem_in;
   logic                           mem_we;
   logic                           capped;
   logic                           send_done;
   logic                           need_space;

   // radix register, saturated to the legal range when a request starts
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rdf_pkg::RADIX_RESET;
      end else if (csr.valid) begin
         radix_ff <= csr.data;
      end
   end

   assign csr.ready = 1'b1;

   always_comb begin
      if (radix_ff < rdf_pkg::RADIX_MIN) begin
         base_in = rdf_pkg::RADIX_MIN;
      end else if (radix_ff > rdf_pkg::RADIX_MAX) begin
         base_in = rdf_pkg::RADIX_MAX;
      end else begin
         base_in = radix_ff;
      end
   end

   // restoring divider step: one quotient bit per cycle
   assign rem_shift = {rem_ff, quot_ff[rdf_pkg::VALUE_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, base_ff};
   assign rem_diff  = rem_shift - {1'b0, base_ff};
   assign rem_in    = rem_ge ? rem_diff[rdf_pkg::RADIX_W-1:0]
                             : rem_shift[rdf_pkg::RADIX_W-1:0];
   assign mem_we    = (state_ff == ST_DIV) && (bit_ff == BIT_LAST);

   // digit memory, least significant digit at slot 0
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[slot_ff] <= rem_in;
      end
      rd_ff <= digit_mem[slot_ff];
   end

   // characters past the cap are dropped, the newline never is
   assign capped     = (cnt_ff >= rdf_pkg::CHAR_CAP) && !last_ff;
   assign send_done  = capped || rsp.ready;
   assign need_space = (slot_ff != SLOT_TOP) && (slot_ff[1:0] == 2'b11);

   // sequencer: divide, then walk digits from the top slot down
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
         pend_ff    <= 1'b0;
         last_ff    <= 1'b0;
         slot_ff    <= '0;
         bit_ff     <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  quot_ff    <= req.value;
                  rem_ff     <= '0;
                  base_ff    <= base_in;
                  bit_ff     <= '0;
                  slot_ff    <= '0;
                  cnt_ff     <= '0;
                  started_ff <= 1'b0;
                  pend_ff    <= 1'b0;
                  last_ff    <= 1'b0;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               quot_ff <= {quot_ff[rdf_pkg::VALUE_W-2:0], rem_ge};
               bit_ff  <= bit_ff + 1'b1;
               if (bit_ff == BIT_LAST) begin
                  rem_ff <= '0;
                  if (slot_ff == SLOT_TOP) begin
                     state_ff <= ST_RD;
                  end else begin
                     slot_ff <= slot_ff + 1'b1;
                  end
               end else begin
                  rem_ff <= rem_in;
               end
            end
            ST_RD: begin
               state_ff <= ST_LOOK;
            end
            ST_LOOK: begin
               if (started_ff || (rd_ff != '0)) begin
                  started_ff <= 1'b1;
                  state_ff   <= ST_SEND;
                  if (need_space) begin
                     char_ff <= rdf_pkg::CHAR_SPACE;
                     pend_ff <= 1'b1;
                  end else begin
                     char_ff <= rdf_pkg::digit_char(rd_ff);
                     pend_ff <= 1'b0;
                  end
               end else if (slot_ff == '0) begin
                  state_ff <= ST_TAIL;
               end else begin
                  slot_ff  <= slot_ff - 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_SEND: begin
               if (send_done) begin
                  // the newline is not counted against the cap
                  if (!capped && !last_ff) begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  if (last_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (pend_ff) begin
                     char_ff <= rdf_pkg::digit_char(rd_ff);
                     pend_ff <= 1'b0;
                  end else if (slot_ff == '0) begin
                     state_ff <= ST_TAIL;
                  end else begin
                     slot_ff  <= slot_ff - 1'b1;
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_TAIL: begin
               // zero value prints a single '0' before the newline
               state_ff <= ST_SEND;
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  char_ff    <= rdf_pkg::CHAR_ZERO;
               end else begin
                  char_ff <= rdf_pkg::CHAR_NEWLINE;
                  last_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = (state_ff == ST_SEND) && !capped;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;

   // no new request while a character is on offer
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("request accepted while a response is pending");

   // the last character of a run is always the newline
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last) |-> (rsp.character == rdf_pkg::CHAR_NEWLINE))
      else $error("last flag on a character other than newline");

   // the block is ready again right after the newline is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
      else $error("not idle after end of run");

   // character count stays within the run limit
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= rdf_pkg::CHAR_CAP)
      else $error("character count past the cap");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for radix_digit_formatter, predicts the character stream
// of every request and checks it; depends on rdf_pkg and the rdf_*_if interfaces
module testbench;

   localparam int SLOTS          = rdf_pkg::DIGIT_SLOTS_DEFAULT;
   localparam int GROUP_SIZE     = 4;
   localparam int IDLE_PERCENT   = 14;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 55;

   // expected character stream, one entry per response
   class char_scoreboard;
      typedef struct packed {
         logic [rdf_pkg::CHAR_W-1:0] character;
         logic                       last;
      } char_item_type;

      char_item_type               expected_chars[$];
      logic [rdf_pkg::RADIX_W-1:0] radix_setting;
      int                          error_count;
      int                          run_length;
      int                          chars_seen;

      function new();
         radix_setting = rdf_pkg::RADIX_RESET;
         error_count   = 0;
         chars_seen    = 0;
      endfunction

      task log_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         error_count++;
      endtask

      // characters past the cap are dropped, newline slot stays free
      function void push_char(input logic [rdf_pkg::CHAR_W-1:0] ch);
         char_item_type item;
         if (run_length < rdf_pkg::MAX_RESULTS - 1) begin
            item.character = ch;
            item.last      = 1'b0;
            expected_chars.push_back(item);
            run_length++;
         end
      endfunction

      // predict the characters for one accepted request
      function void note_value(input logic [rdf_pkg::VALUE_W-1:0] value);
         logic [rdf_pkg::RADIX_W-1:0] base;
         logic [rdf_pkg::RADIX_W-1:0] digit_at [SLOTS];
         logic [rdf_pkg::VALUE_W-1:0] rest;
         logic [rdf_pkg::CHAR_W-1:0]  ch;
         bit                          leading_done;
         char_item_type               item;
         // out-of-range radix saturates to the nearest legal base
         if (radix_setting < rdf_pkg::RADIX_MIN) begin
            base = rdf_pkg::RADIX_MIN;
         end else if (radix_setting > rdf_pkg::RADIX_MAX) begin
            base = rdf_pkg::RADIX_MAX;
         end else begin
            base = radix_setting;
         end
         rest = value;
         for (int p = 0; p < SLOTS; p++) begin
            digit_at[p] = rdf_pkg::RADIX_W'(rest % base);
            rest        = rest / base;
         end
         run_length   = 0;
         leading_done = 0;
         for (int p = SLOTS - 1; p >= 0; p--) begin
            if (digit_at[p] != '0) begin
               leading_done = 1;
            end
            if (leading_done) begin
               if (p < SLOTS - 1 && (p % GROUP_SIZE) == GROUP_SIZE - 1) begin
                  push_char(rdf_pkg::CHAR_SPACE);
               end
               if (digit_at[p] < rdf_pkg::DECIMAL_DIGITS) begin
                  ch = rdf_pkg::CHAR_ZERO + rdf_pkg::CHAR_W'(digit_at[p]);
               end else begin
                  ch = rdf_pkg::CHAR_LETTER
                       + rdf_pkg::CHAR_W'(digit_at[p] - rdf_pkg::DECIMAL_DIGITS);
               end
               push_char(ch);
            end
         end
         // zero prints a single digit
         if (!leading_done) begin
            push_char(rdf_pkg::CHAR_ZERO);
         end
         item.character = rdf_pkg::CHAR_NEWLINE;
         item.last      = 1'b1;
         expected_chars.push_back(item);
      endfunction

      // compare one response with the oldest expectation
      task check_char(input logic [rdf_pkg::CHAR_W-1:0] ch, input logic last);
         char_item_type want;
         chars_seen++;
         if (expected_chars.size() == 0) begin
            log_mismatch($sformatf("char %0d: unexpected 0x%02h last %0b",
                                   chars_seen, ch, last));
         end else begin
            want = expected_chars.pop_front();
            if (ch !== want.character) begin
               log_mismatch($sformatf("char %0d: character 0x%02h, expected 0x%02h",
                                      chars_seen, ch, want.character));
            end
            if (last !== want.last) begin
               log_mismatch($sformatf("char %0d: last %0b, expected %0b",
                                      chars_seen, last, want.last));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   steady_flow = 0;
   int   quiet_cycles;

   char_scoreboard sb;

   rdf_req_if req_if ();
   rdf_rsp_if rsp_if ();
   rdf_csr_if csr_if ();

   radix_digit_formatter #(
      .DIGIT_SLOTS(SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   // clock generation
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_char(rsp_if.character, rsp_if.last);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // send one request, with random gaps ahead of it
   task automatic send_value(input logic [rdf_pkg::VALUE_W-1:0] value);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= value;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sb.note_value(value);
   endtask

   // hold off requests until every expected character has come
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // radix write, only with the block idle
   task automatic set_radix(input logic [rdf_pkg::RADIX_W-1:0] radix);
      drain_results();
      csr_if.valid <= 1'b1;
      csr_if.data  <= radix;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      sb.radix_setting = radix;
      csr_if.valid <= 1'b0;
   endtask

   // mix of short, long and boundary values
   function automatic logic [rdf_pkg::VALUE_W-1:0] random_value();
      logic [rdf_pkg::VALUE_W-1:0] value;
      case ($urandom_range(0, 5))
         0: value = rdf_pkg::VALUE_W'($urandom_range(0, 40));
         1: value = $urandom >> $urandom_range(0, 31);
         2: value = 32'hFFFF_FFFF - rdf_pkg::VALUE_W'($urandom_range(0, 1000));
         3: value = 32'h1 << $urandom_range(0, 31);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   // stimulus
   initial begin
      logic [rdf_pkg::RADIX_W-1:0] phase_radix [8];
      sb = new();
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.value <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset radix, decimal edge values and a leading group space
      send_value(32'h0);
      send_value(32'h1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd1000);
      send_value(32'hFFFF_FFFF);
      // binary: the longest run fills every result slot
      set_radix(6'd2);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h0);
      send_value(32'h8);
      // largest base, letter digits
      set_radix(rdf_pkg::RADIX_MAX);
      send_value(32'd35);
      send_value(32'd36);
      send_value(32'hFFFF_FFFF);
      // radix below two and above thirty-six saturate
      set_radix(6'd0);
      send_value(32'd5);
      set_radix(6'd1);
      send_value(32'hFFFF_FFFF);
      set_radix(6'd37);
      send_value(32'hFFFF_FFFF);
      set_radix(6'd63);
      send_value(32'd1296);
      set_radix(6'd16);
      send_value(32'hDEAD_BEEF);
      send_value(32'hA);

      // random phases, one radix each
      phase_radix[0] = 6'd2;
      phase_radix[1] = rdf_pkg::RADIX_MAX;
      phase_radix[2] = rdf_pkg::RADIX_RESET;
      phase_radix[3] = rdf_pkg::RADIX_W'($urandom_range(0, 63));
      phase_radix[4] = 6'd16;
      phase_radix[5] = 6'd63;
      phase_radix[6] = rdf_pkg::RADIX_W'($urandom_range(0, 63));
      phase_radix[7] = rdf_pkg::RADIX_W'($urandom_range(2, 36));
      for (int ph = 0; ph < 8; ph++) begin
         set_radix(phase_radix[ph]);
         steady_flow = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_value(random_value());
            if ($urandom_range(0, 49) == 0) begin
               drain_results();
            end
         end
      end
      steady_flow = 0;

      // wind down
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_chars.size() != 0) begin
         sb.log_mismatch($sformatf("%0d characters never arrived",
                                   sb.expected_chars.size()));
      end
      if (sb.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
